// File: src/buffer_frame_table_clock_top_macros.svh
// Assertion macros used by the frame table controller
`ifndef BUFFER_FRAME_TABLE_CLOCK_TOP_MACROS_SVH
`define BUFFER_FRAME_TABLE_CLOCK_TOP_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle
`define BFTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Check that an antecedent implies a consequent in the next cycle
`define BFTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: src/bftc_pkg.sv
package bftc_pkg;

    localparam logic [1:0] OP_ACCESS = 2'd0;
    localparam logic [1:0] OP_PIN    = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_FREE    = 3'd1;
    localparam logic [2:0] ST_EVICT   = 3'd2;
    localparam logic [2:0] ST_NOFRAME = 3'd3;
    localparam logic [2:0] ST_PIN     = 3'd4;
    localparam logic [2:0] ST_FLUSH   = 3'd5;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;     // capture input word
        logic scan_clr;    // reset scan index to zero
        logic scan_hand;   // reset scan index to the clock hand
        logic scan_step;   // advance scan index
        logic do_hit;      // apply hit at scan index
        logic do_load;     // load page at scan index
        logic do_evict;    // evict at scan index then load
        logic do_clear_ref;// clear ref flag at scan index, advance hand
        logic do_pin;      // apply pin adjust
        logic do_flush;    // invalidate frame at scan index
        logic out_set;     // load output register
        logic [2:0] out_status;
        logic out_last;
    } bftc_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic match;       // scan frame valid with matching tag
        logic empty;       // scan frame invalid
        logic victim;      // scan frame unpinned, unreferenced
        logic scan_end;    // step count reached FRAME_COUNT - 1
        logic any_valid_after; // some valid frame above scan index
    } bftc_stat_t;

endpackage

// File: src/bftc_datapath.sv
module bftc_datapath
    import bftc_pkg::*;
#(
    parameter int FRAME_COUNT = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bftc_cmd_t            cmd,
    output bftc_stat_t           stat,
    input  logic [1:0]           opcode,
    input  logic [15:0]          page_tag,
    input  logic [15:0]          page_block,
    input  logic                 mark_dirty,
    input  logic [5:0]           frame_index,
    input  logic signed [7:0]    pin_delta,
    output logic [5:0]           frame_slot,
    output logic [2:0]           status,
    output logic                 writeback,
    output logic [15:0]          writeback_block,
    output logic                 last
);
    localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_COUNT - 1);

    logic [FRAME_COUNT-1:0] valid_reg, dirty_reg, ref_reg;
    logic [7:0]            pin_reg [FRAME_COUNT];
    logic [15:0]           tag_reg [FRAME_COUNT];
    logic [15:0]           blk_reg [FRAME_COUNT];
    logic [IW-1:0]         hand_reg, idx_reg;
    logic [IW:0]           cnt_reg;
    logic [1:0]            op_reg;
    logic [15:0]           tag_in_reg, blk_in_reg;
    logic                  md_in_reg;
    logic [5:0]            fi_reg;
    logic signed [7:0]     dl_reg;

    logic [FRAME_COUNT-1:0] above;
    logic                  fi_ok;
    logic [IW-1:0]         fi_idx;
    logic signed [9:0]     pin_sum;
    logic [7:0]            pin_sat;

    assign fi_ok   = {1'b0, fi_reg} < 7'(FRAME_COUNT);
    assign fi_idx  = fi_reg[IW-1:0];
    assign pin_sum = $signed({2'b00, pin_reg[fi_idx]}) + 10'(dl_reg);
    assign pin_sat = (pin_sum < 0) ? 8'd0 : (pin_sum > 10'sd255) ? 8'd255 : pin_sum[7:0];

    // Mark frames above scan index
    always_comb
    begin
        for (int i = 0; i < FRAME_COUNT; i++)
        begin
            above[i] = IW'(i) > idx_reg;
        end
    end

    // Scan ends after FRAME_COUNT frames, whatever index it started from
    assign stat.opcode          = op_reg;
    assign stat.match           = valid_reg[idx_reg] && (tag_reg[idx_reg] == tag_in_reg);
    assign stat.empty           = !valid_reg[idx_reg];
    assign stat.victim          = (pin_reg[idx_reg] == 8'd0) && !ref_reg[idx_reg];
    assign stat.scan_end        = (cnt_reg == (IW+1)'(FRAME_COUNT - 1));
    assign stat.any_valid_after = |(valid_reg & above);

    // Capture input word and drive scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= OP_ACCESS;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                op_reg <= opcode;
            end
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.scan_hand)
            begin
                idx_reg <= hand_reg;
                cnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            tag_in_reg <= page_tag;
            blk_in_reg <= page_block;
            md_in_reg  <= mark_dirty;
            fi_reg     <= frame_index;
            dl_reg     <= pin_delta;
        end
    end

    // Update frame table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            ref_reg   <= '0;
            hand_reg  <= '0;
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                pin_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (cmd.do_hit)
            begin
                dirty_reg[idx_reg] <= dirty_reg[idx_reg] | md_in_reg;
            end
            if (cmd.do_load)
            begin
                valid_reg[idx_reg] <= 1'b1;
                dirty_reg[idx_reg] <= dirty_reg[idx_reg] | md_in_reg;
            end
            if (cmd.do_evict)
            begin
                valid_reg[idx_reg] <= 1'b1;
                dirty_reg[idx_reg] <= md_in_reg;
                pin_reg[idx_reg]   <= 8'd0;
            end
            if (cmd.do_clear_ref)
            begin
                ref_reg[idx_reg] <= 1'b0;
                hand_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            if (cmd.do_pin && fi_ok)
            begin
                pin_reg[fi_idx] <= pin_sat;
                if (pin_sat == 8'd0)
                begin
                    ref_reg[fi_idx] <= 1'b1;
                end
            end
            if (cmd.do_flush)
            begin
                valid_reg[idx_reg] <= 1'b0;
                dirty_reg[idx_reg] <= 1'b0;
                pin_reg[idx_reg]   <= 8'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_load || cmd.do_evict)
        begin
            tag_reg[idx_reg] <= tag_in_reg;
            blk_reg[idx_reg] <= blk_in_reg;
        end
    end

    // Build output word
    always_ff @(posedge clk)
    begin
        if (cmd.out_set)
        begin
            status <= cmd.out_status;
            last   <= cmd.out_last;
            unique case (cmd.out_status)
                ST_PIN:
                begin
                    frame_slot      <= fi_reg;
                    writeback       <= 1'b0;
                    writeback_block <= 16'd0;
                end
                ST_NOFRAME:
                begin
                    frame_slot      <= 6'd0;
                    writeback       <= 1'b0;
                    writeback_block <= 16'd0;
                end
                ST_FLUSH:
                begin
                    frame_slot      <= 6'(idx_reg);
                    writeback       <= 1'b1;
                    writeback_block <= blk_reg[idx_reg];
                end
                ST_EVICT:
                begin
                    frame_slot      <= 6'(idx_reg);
                    writeback       <= dirty_reg[idx_reg];
                    writeback_block <= dirty_reg[idx_reg] ? blk_reg[idx_reg] : 16'd0;
                end
                default:
                begin
                    frame_slot      <= 6'(idx_reg);
                    writeback       <= 1'b0;
                    writeback_block <= 16'd0;
                end
            endcase
        end
    end
endmodule

// File: src/bftc_ctrl.sv
`include "buffer_frame_table_clock_top_macros.svh"
module bftc_ctrl
    import bftc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  bftc_stat_t stat,
    output bftc_cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_LOOKUP, S_FREE, S_CLOCK, S_FLUSH, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   busy;

    assign busy      = state_reg != S_IDLE;
    assign in_stall  = busy;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in  = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.opcode)
                    OP_ACCESS: state_next = S_LOOKUP;
                    OP_PIN:    state_next = S_OUT;
                    OP_FLUSH:  state_next = S_FLUSH;
                    default:   state_next = S_IDLE;
                endcase
            end
            // Search for a tag match
            S_LOOKUP:
            begin
                if (stat.match)
                begin
                    if (!ov_reg)
                    begin
                        cmd.do_hit = 1'b1;
                        cmd.out_set = 1'b1;
                        cmd.out_status = ST_HIT;
                        cmd.out_last = 1'b1;
                        ov_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.scan_end)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next = S_FREE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            // Search for the lowest empty frame
            S_FREE:
            begin
                if (stat.empty)
                begin
                    if (!ov_reg)
                    begin
                        cmd.do_load = 1'b1;
                        cmd.out_set = 1'b1;
                        cmd.out_status = ST_FREE;
                        cmd.out_last = 1'b1;
                        ov_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.scan_end)
                begin
                    cmd.scan_hand = 1'b1;
                    state_next = S_CLOCK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            // Sweep the clock hand once
            S_CLOCK:
            begin
                if (!ov_reg)
                begin
                    if (stat.victim)
                    begin
                        cmd.do_evict = 1'b1;
                        cmd.out_set = 1'b1;
                        cmd.out_status = ST_EVICT;
                        cmd.out_last = 1'b1;
                        ov_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.do_clear_ref = 1'b1;
                        cmd.scan_step = 1'b1;
                        if (stat.scan_end)
                        begin
                            cmd.out_set = 1'b1;
                            cmd.out_status = ST_NOFRAME;
                            cmd.out_last = 1'b1;
                            ov_next = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            // Emit one word per valid frame
            S_FLUSH:
            begin
                if (!stat.empty)
                begin
                    if (!ov_reg)
                    begin
                        cmd.out_set = 1'b1;
                        cmd.out_status = ST_FLUSH;
                        cmd.out_last = !stat.any_valid_after;
                        cmd.do_flush = 1'b1;
                        ov_next = 1'b1;
                        if (stat.any_valid_after)
                        begin
                            cmd.scan_step = 1'b1;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (stat.any_valid_after)
                begin
                    cmd.scan_step = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    cmd.do_pin = 1'b1;
                    cmd.out_set = 1'b1;
                    cmd.out_status = ST_PIN;
                    cmd.out_last = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    `BFTC_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_set, !ov_reg)
    `BFTC_ASSERT_NEXT(a_set_valid, clk, rst_n, cmd.out_set, ov_reg)
    `BFTC_ASSERT_IMPL(a_load_idle, clk, rst_n, cmd.load_in, state_reg == S_IDLE)
endmodule

// File: src/buffer_frame_table_clock_top.sv
// Frame table with clock replacement for a page buffer pool, one word at a time.
// A pin adjust goes from decode to its result; an access runs a lookup, on a miss a
// free-frame scan, then a clock sweep, one frame a cycle; the sweep waits on a held result.
// Flush scans one frame a cycle, but a valid frame waits until the last word is taken;
// the next word is accepted the cycle after the last result is loaded, held or not.
// Reset (rst_n low, asynchronous) empties all frames, clears pin, dirty, ref, hand.
module buffer_frame_table_clock_top
    import bftc_pkg::*;
#(
    parameter int FRAME_COUNT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [15:0]       page_tag,
    input  logic [15:0]       page_block,
    input  logic              mark_dirty,
    input  logic [5:0]        frame_index,
    input  logic signed [7:0] pin_delta,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [5:0]        frame_slot,
    output logic [2:0]        status,
    output logic              writeback,
    output logic [15:0]       writeback_block,
    output logic              last
);
    bftc_cmd_t  cmd;
    bftc_stat_t stat;

    bftc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
    );

    bftc_datapath #(.FRAME_COUNT(FRAME_COUNT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .opcode(opcode), .page_tag(page_tag), .page_block(page_block),
        .mark_dirty(mark_dirty), .frame_index(frame_index), .pin_delta(pin_delta),
        .frame_slot(frame_slot), .status(status), .writeback(writeback),
        .writeback_block(writeback_block), .last(last)
    );
endmodule

// File: tb/sv/tb_buffer_frame_table_clock_top.sv
module tb_buffer_frame_table_clock_top;
    import bftc_pkg::*;

    localparam int FRAMES = 8;

    typedef struct {
        logic [1:0]        op;
        logic [15:0]       tag;
        logic [15:0]       blk;
        logic              md;
        logic [5:0]        idx;
        logic signed [7:0] delta;
    } page_req_t;

    typedef struct {
        logic [5:0]  slot;
        logic [2:0]  st;
        logic        wb;
        logic [15:0] wb_blk;
        logic        lst;
    } frame_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] opcode = '0;
    logic [15:0] page_tag = '0;
    logic [15:0] page_block = '0;
    logic mark_dirty = 1'b0;
    logic [5:0] frame_index = '0;
    logic signed [7:0] pin_delta = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [5:0] frame_slot;
    logic [2:0] status;
    logic writeback;
    logic [15:0] writeback_block;
    logic last;

    page_req_t   pending_reqs[$];
    frame_resp_t expected_resps[$];
    int errors = 0;
    bit stim_done = 0;
    int hold_off = 0;

    // shadow frame table
    bit          fv[FRAMES];
    logic [15:0] ftag[FRAMES];
    logic [15:0] fblk[FRAMES];
    logic [7:0]  fpin[FRAMES];
    bit          fdirty[FRAMES];
    bit          fref[FRAMES];
    int          hand;

    buffer_frame_table_clock_top #(.FRAME_COUNT(FRAMES)) DUT (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic frame_resp_t mk(int slot, logic [2:0] st, bit wb,
                                       logic [15:0] b, bit l);
        frame_resp_t r;
        r.slot = slot[5:0];
        r.st = st;
        r.wb = wb;
        r.wb_blk = b;
        r.lst = l;
        return r;
    endfunction

    task automatic predict_frames(page_req_t q);
        int i;
        int v;
        int slot;
        int first;
        int n;
        logic [2:0] st;
        bit wb;
        logic [15:0] wbb;
        bit found;
        begin
            found = 0;
            wb = 0;
            wbb = '0;
            slot = 0;
            st = ST_NOFRAME;
            case (q.op)
                OP_ACCESS:
                begin
                    // look up
                    for (i = 0; i < FRAMES; i++)
                        if (!found && fv[i] && ftag[i] == q.tag)
                        begin
                            found = 1;
                            fdirty[i] |= q.md;
                            expected_resps.push_back(mk(i, ST_HIT, 0, 0, 1));
                        end
                    if (found)
                        return;
                    // lowest empty frame
                    for (i = 0; i < FRAMES; i++)
                        if (!found && !fv[i])
                        begin
                            found = 1;
                            slot = i;
                            st = ST_FREE;
                        end
                    // clock pass
                    for (n = 0; n < FRAMES && !found; n++)
                    begin
                        if (fpin[hand] == 0 && !fref[hand])
                        begin
                            if (fdirty[hand])
                            begin
                                wb = 1;
                                wbb = fblk[hand];
                            end
                            fdirty[hand] = 0;
                            fpin[hand] = 0;
                            slot = hand;
                            st = ST_EVICT;
                            found = 1;
                        end
                        else
                        begin
                            fref[hand] = 0;
                            hand = (hand + 1) % FRAMES;
                        end
                    end
                    if (!found)
                    begin
                        expected_resps.push_back(mk(0, ST_NOFRAME, 0, 0, 1));
                        return;
                    end
                    fv[slot] = 1;
                    ftag[slot] = q.tag;
                    fblk[slot] = q.blk;
                    fdirty[slot] |= q.md;
                    expected_resps.push_back(mk(slot, st, wb, wbb, 1));
                end
                OP_PIN:
                begin
                    if (q.idx < FRAMES)
                    begin
                        v = int'(fpin[q.idx]) + int'(q.delta);
                        if (v < 0) v = 0;
                        if (v > 255) v = 255;
                        fpin[q.idx] = v[7:0];
                        if (v == 0)
                            fref[q.idx] = 1;
                    end
                    expected_resps.push_back(mk(q.idx, ST_PIN, 0, 0, 1));
                end
                OP_FLUSH:
                begin
                    first = expected_resps.size();
                    for (i = 0; i < FRAMES; i++)
                        if (fv[i])
                        begin
                            expected_resps.push_back(mk(i, ST_FLUSH, 1, fblk[i], 0));
                            fv[i] = 0;
                            fdirty[i] = 0;
                            fpin[i] = 0;
                        end
                    if (expected_resps.size() > first)
                        expected_resps[expected_resps.size() - 1].lst = 1;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    function automatic page_req_t rand_req(int tag_span);
        page_req_t q;
        int r;
        r = $urandom_range(99);
        q.op = (r < 55) ? OP_ACCESS : (r < 90) ? OP_PIN : (r < 96) ? OP_FLUSH : 2'd3;
        q.tag = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(tag_span));
        q.blk = 16'($urandom);
        q.md = 1'($urandom);
        q.idx = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(FRAMES - 1));
        case ($urandom_range(3))
            0: q.delta = 8'($urandom);
            1: q.delta = 8'sd1;
            2: q.delta = -8'sd1;
            default: q.delta = 8'($signed($urandom_range(4)) - 2);
        endcase
        return q;
    endfunction

    function automatic page_req_t dreq(logic [1:0] op, logic [15:0] tag, logic [15:0] blk,
                                       logic md, logic [5:0] idx, logic signed [7:0] d);
        page_req_t q;
        q.op = op;
        q.tag = tag;
        q.blk = blk;
        q.md = md;
        q.idx = idx;
        q.delta = d;
        return q;
    endfunction

    // stimulus
    initial
    begin
        int i;
        for (i = 0; i < FRAMES; i++)
        begin
            fv[i] = 0;
            ftag[i] = '0;
            fblk[i] = '0;
            fpin[i] = '0;
            fdirty[i] = 0;
            fref[i] = 0;
        end
        hand = 0;
        // flush of an empty table, unused opcode
        pending_reqs.push_back(dreq(OP_FLUSH, 0, 0, 0, 0, 0));
        pending_reqs.push_back(dreq(2'd3, 16'hFFFF, 16'hFFFF, 1, 6'h3F, -8'sd128));
        // fill every frame, both extremes of the tag, the lowest block
        for (i = 0; i < FRAMES; i++)
            pending_reqs.push_back(dreq(OP_ACCESS, (i == 7) ? 16'hFFFF : i[15:0],
                (i == 0) ? 16'h0000 : 16'hFFFF - i[15:0], i[0], 0, 0));
        pending_reqs.push_back(dreq(OP_ACCESS, 16'hFFFF, 16'h1234, 1, 0, 0));
        // saturate high and low, out-of-range index
        pending_reqs.push_back(dreq(OP_PIN, 0, 0, 0, 0, 8'sd127));
        pending_reqs.push_back(dreq(OP_PIN, 0, 0, 0, 0, 8'sd127));
        pending_reqs.push_back(dreq(OP_PIN, 0, 0, 0, 0, 8'sd127));
        pending_reqs.push_back(dreq(OP_PIN, 0, 0, 0, 1, -8'sd128));
        pending_reqs.push_back(dreq(OP_PIN, 0, 0, 0, 6'h3F, 8'sd5));
        pending_reqs.push_back(dreq(OP_PIN, 0, 0, 0, 6'd8, -8'sd1));
        // pin every frame so a miss finds no frame, then release and evict
        for (i = 1; i < FRAMES; i++)
            pending_reqs.push_back(dreq(OP_PIN, 0, 0, 0, i[5:0], 8'sd1));
        pending_reqs.push_back(dreq(OP_ACCESS, 16'h5555, 16'hAAAA, 0, 0, 0));
        pending_reqs.push_back(dreq(OP_PIN, 0, 0, 0, 3, -8'sd1));
        pending_reqs.push_back(dreq(OP_ACCESS, 16'h6666, 16'h7777, 1, 0, 0));
        pending_reqs.push_back(dreq(OP_ACCESS, 16'h6667, 16'h7778, 0, 0, 0));
        pending_reqs.push_back(dreq(OP_FLUSH, 0, 0, 0, 0, 0));
        for (i = 0; i < 220; i++)
            pending_reqs.push_back(rand_req((i < 110) ? 11 : 40));
        stim_done = 1;
    end

    // driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        page_req_t q;
        if (rst_n)
        begin
            if (!(in_valid && in_stall))
            begin
                // drop the accepted word, the next one is then at the head
                if (in_valid)
                    void'(pending_reqs.pop_front());
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    q = pending_reqs[0];
                    in_valid <= 1'b1;
                    opcode <= q.op;
                    page_tag <= q.tag;
                    page_block <= q.blk;
                    mark_dirty <= q.md;
                    frame_index <= q.idx;
                    pin_delta <= q.delta;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(12, 1);
                        gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // predict on acceptance
    always @(posedge clk)
    begin
        page_req_t q;
        if (rst_n && in_valid && !in_stall)
        begin
            q.op = opcode;
            q.tag = page_tag;
            q.blk = page_block;
            q.md = mark_dirty;
            q.idx = frame_index;
            q.delta = pin_delta;
            predict_frames(q);
        end
    end

    // receiver stall pattern, with one long hold-off
    int stall_phase = 0;
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else if (stall_phase == 900)
        begin
            hold_off <= 400;
            out_stall <= 1'b1;
        end
        else if ((stall_phase / 64) % 3 == 0)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(3) == 0);
    end

    // monitor
    always @(posedge clk)
    begin
        frame_resp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_resps.size() == 0)
            begin
                $error("unexpected word slot=%0d status=%0d", frame_slot, status);
                errors++;
            end
            else
            begin
                e = expected_resps.pop_front();
                if (frame_slot !== e.slot)
                begin
                    $error("frame_slot expected %0d actual %0d", e.slot, frame_slot);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errors++;
                end
                if (writeback !== e.wb)
                begin
                    $error("writeback expected %0d actual %0d", e.wb, writeback);
                    errors++;
                end
                if (writeback_block !== e.wb_blk)
                begin
                    $error("writeback_block expected %h actual %h", e.wb_blk,
                           writeback_block);
                    errors++;
                end
                if (last !== e.lst)
                begin
                    $error("last expected %0d actual %0d", e.lst, last);
                    errors++;
                end
            end
        end
    end

    // reset, then wait for drain
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
            @(posedge clk);
        repeat (3 * FRAMES + 10) @(posedge clk);
        if (errors == 0 && expected_resps.size() == 0)
            $display("tb_buffer_frame_table_clock_top: PASS");
        else
            $display("tb_buffer_frame_table_clock_top: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("tb_buffer_frame_table_clock_top: FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/bftc_pkg.sv
src/bftc_datapath.sv
src/bftc_ctrl.sv
src/buffer_frame_table_clock_top.sv
tb/sv/tb_buffer_frame_table_clock_top.sv
